// ===== rtl/iwrs_pkg.sv =====
package iwrs_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_CONT  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [1:0] ST_WAIT_DATA = 2'd0;
    localparam logic [1:0] ST_WAIT_SEND = 2'd1;
    localparam logic [1:0] ST_SENDING   = 2'd2;

    localparam logic [2:0] MS_IDLE      = 3'd0;
    localparam logic [2:0] MS_RX_READY  = 3'd1;
    localparam logic [2:0] MS_TX_READY  = 3'd2;
    localparam logic [2:0] MS_NACK_ADDR = 3'd3;

    localparam logic [7:0] READ_BIT    = 8'h01;
    localparam logic [7:0] LIMIT_RESET = 8'd8;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] device_address;
        logic [4:0] send_count;
        logic [4:0] read_count;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
        logic       arb_lost;
        logic       start_stop_error;
        logic       master_pending;
        logic [2:0] master_state;
    } t_in_item;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [1:0] command;
        logic       clear_arb_lost;
        logic       clear_start_stop_error;
        logic       irq_enabled;
        logic [1:0] status;
        logic [7:0] read_byte;
    } t_out_item;

endpackage

// ===== rtl/iwrs_in_if.sv =====
interface iwrs_in_if import iwrs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/iwrs_out_if.sv =====
interface iwrs_out_if import iwrs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/iwrs_buf.sv =====
module iwrs_buf #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // forward a same-cycle write to the read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/iwrs_ctrl.sv =====
module iwrs_ctrl import iwrs_pkg::*; #(
    parameter int SEND_DEPTH = 16,
    parameter int READ_DEPTH = 16,
    localparam int SCW = $clog2(SEND_DEPTH + 1),
    localparam int RCW = $clog2(READ_DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  t_in_item       i_item,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_data,
    input  logic [7:0]     i_send_rdata,
    input  logic [7:0]     i_recv_rdata,
    output logic [SCW-1:0] o_send_ptr,
    output logic           o_recv_we,
    output logic [RCW-1:0] o_recv_ptr,
    output t_out_item      o_result
);

    logic [7:0]     r_limit;
    logic [SCW-1:0] r_sent, n_sent;
    logic [RCW-1:0] r_recv, n_recv;
    logic [SCW-1:0] r_to_send, n_to_send;
    logic [RCW-1:0] r_to_read, n_to_read;
    logic [7:0]     r_addr, n_addr;
    logic           r_reading, n_reading;
    logic [1:0]     r_status, n_status;
    logic           r_irq, n_irq;
    logic [7:0]     r_flagless, n_flagless;
    logic           recv_we;
    t_out_item      res;

    always_comb begin
        n_sent     = r_sent;
        n_recv     = r_recv;
        n_to_send  = r_to_send;
        n_to_read  = r_to_read;
        n_addr     = r_addr;
        n_reading  = r_reading;
        n_status   = r_status;
        n_irq      = r_irq;
        n_flagless = r_flagless;
        recv_we    = 1'b0;
        res        = '0;
        res.command = CMD_NONE;
        if (i_advance) begin
            unique case (i_item.opcode)
                OP_LOAD: begin
                end
                OP_START: begin
                    n_addr = i_item.device_address;
                    n_to_send = (32'(i_item.send_count) > SEND_DEPTH) ?
                        SCW'(SEND_DEPTH) : SCW'(i_item.send_count);
                    n_to_read = (32'(i_item.read_count) > READ_DEPTH) ?
                        RCW'(READ_DEPTH) : RCW'(i_item.read_count);
                    n_status   = ST_WAIT_SEND;
                    n_flagless = '0;
                    n_sent     = '0;
                    n_recv     = '0;
                    if (n_to_send != '0) begin
                        n_reading      = 1'b0;
                        res.data_valid = 1'b1;
                        res.data_byte  = i_item.device_address;
                    end else if (n_to_read != '0) begin
                        n_reading      = 1'b1;
                        res.data_valid = 1'b1;
                        res.data_byte  = i_item.device_address | READ_BIT;
                    end
                    res.clear_arb_lost         = 1'b1;
                    res.clear_start_stop_error = 1'b1;
                    res.command                = CMD_START;
                    n_irq                      = 1'b1;
                end
                OP_EVENT: begin
                    if (i_item.arb_lost) begin
                        res.clear_arb_lost = 1'b1;
                        n_irq              = 1'b0;
                        n_status           = ST_WAIT_DATA;
                    end else if (i_item.start_stop_error) begin
                        res.clear_start_stop_error = 1'b1;
                        n_irq                      = 1'b0;
                        n_status                   = ST_WAIT_DATA;
                    end else if (i_item.master_pending) begin
                        unique case (i_item.master_state) inside
                            MS_IDLE: begin
                                n_irq    = 1'b0;
                                n_status = ST_WAIT_DATA;
                            end
                            MS_RX_READY: begin
                                res.command = ({1'b0, r_to_read} ==
                                    ({1'b0, r_recv} + (RCW + 1)'(1))) ? CMD_STOP : CMD_CONT;
                                if (32'(r_recv) < READ_DEPTH) begin
                                    recv_we = 1'b1;
                                    n_recv  = r_recv + RCW'(1);
                                end
                            end
                            MS_TX_READY, MS_NACK_ADDR: begin
                                if (!r_reading) begin
                                    n_status = ST_SENDING;
                                    if (r_sent >= r_to_send) begin
                                        if (r_to_read != '0) begin
                                            n_reading      = 1'b1;
                                            n_recv         = '0;
                                            res.data_valid = 1'b1;
                                            res.data_byte  = r_addr | READ_BIT;
                                            res.command    = CMD_START;
                                        end else begin
                                            res.command = CMD_STOP;
                                        end
                                    end else begin
                                        res.data_valid = 1'b1;
                                        res.data_byte  = i_send_rdata;
                                        res.command    = CMD_CONT;
                                        n_sent         = r_sent + SCW'(1);
                                    end
                                end else begin
                                    res.command = CMD_STOP;
                                end
                            end
                            default: begin
                                res.command = CMD_STOP;
                            end
                        endcase
                    end else begin
                        if (r_flagless >= r_limit) begin
                            n_irq    = 1'b0;
                            n_status = ST_WAIT_DATA;
                        end else begin
                            n_flagless = r_flagless + 8'd1;
                        end
                    end
                end
                OP_READ: begin
                    if (32'(i_item.byte_index) < READ_DEPTH) begin
                        res.read_byte = i_recv_rdata;
                    end
                end
                default: begin
                end
            endcase
        end
        res.irq_enabled = n_irq;
        res.status      = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_sent     <= '0;
            r_recv     <= '0;
            r_to_send  <= '0;
            r_to_read  <= '0;
            r_addr     <= '0;
            r_reading  <= 1'b0;
            r_status   <= ST_WAIT_DATA;
            r_irq      <= 1'b0;
            r_flagless <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_sent     <= n_sent;
            r_recv     <= n_recv;
            r_to_send  <= n_to_send;
            r_to_read  <= n_to_read;
            r_addr     <= n_addr;
            r_reading  <= n_reading;
            r_status   <= n_status;
            r_irq      <= n_irq;
            r_flagless <= n_flagless;
        end
    end

    assign o_send_ptr = n_sent;
    assign o_recv_we  = recv_we;
    assign o_recv_ptr = r_recv;
    assign o_result   = res;

endmodule

// ===== rtl/i2c_write_read_sequencer_unit.sv =====
// I2C write-then-read sequencer.
// Input channel i_in carries one item per handshake: load a send byte,
// start a transaction, a master status event, or read a received byte.
// Output channel o_out returns exactly one result item per input item:
// the byte to put into the master data register, the bus command, flag
// clears, the interrupt enable and the transfer status.
// i_cfg_we/i_cfg_data write the flagless event limit; write it only idle.
// An accepted item is held in the input register and its result is
// registered once the result register is free. Throughput is one item
// per cycle while o_out does not stall: the input register, one pass of
// control logic and the result register form two stages, and both
// buffers are memories with a registered read port.
// Reset clears all progress counters, status and interrupt enable and
// sets the limit to 8; buffer contents stay undefined until loaded.
// When o_out stalls the result holds, the input register still fills once,
// and i_in.ready then drops until the result is taken.
module i2c_write_read_sequencer_unit import iwrs_pkg::*; #(
    parameter int SEND_DEPTH = 16,
    parameter int READ_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    iwrs_in_if.sink    i_in,
    iwrs_out_if.source o_out
);

    localparam int SCW = $clog2(SEND_DEPTH + 1);
    localparam int RCW = $clog2(READ_DEPTH + 1);
    localparam int SAW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
    localparam int RAW = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1;

    logic           r_in_valid;
    t_in_item       r_in;
    logic           r_out_valid;
    t_out_item      r_out;

    logic           in_fire;
    logic           in_ready;
    logic           advance;
    logic [SCW-1:0] send_ptr;
    logic           recv_we;
    logic [RCW-1:0] recv_ptr;
    logic [7:0]     send_rdata;
    logic [7:0]     recv_rdata;
    t_out_item      result;
    logic           send_we;
    logic [SAW-1:0] send_raddr;
    logic [RAW-1:0] recv_raddr;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;
    assign in_fire  = i_in.valid && in_ready;

    assign send_we = advance && (r_in.opcode == OP_LOAD) &&
                     (32'(r_in.byte_index) < SEND_DEPTH);
    assign send_raddr = (32'(send_ptr) < SEND_DEPTH) ? SAW'(send_ptr) : '0;
    assign recv_raddr = (32'(i_in.data.byte_index) < READ_DEPTH) ?
                        RAW'(i_in.data.byte_index) : '0;

    iwrs_buf #(
        .DEPTH(SEND_DEPTH)
    ) u_send_buf (
        .i_clk   (i_clk),
        .i_we    (send_we),
        .i_waddr (SAW'(r_in.byte_index)),
        .i_wdata (r_in.byte_value),
        .i_re    (1'b1),
        .i_raddr (send_raddr),
        .o_rdata (send_rdata)
    );

    iwrs_buf #(
        .DEPTH(READ_DEPTH)
    ) u_recv_buf (
        .i_clk   (i_clk),
        .i_we    (recv_we),
        .i_waddr (RAW'(recv_ptr)),
        .i_wdata (r_in.byte_value),
        .i_re    (in_fire),
        .i_raddr (recv_raddr),
        .o_rdata (recv_rdata)
    );

    iwrs_ctrl #(
        .SEND_DEPTH(SEND_DEPTH),
        .READ_DEPTH(READ_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_send_rdata (send_rdata),
        .i_recv_rdata (recv_rdata),
        .o_send_ptr   (send_ptr),
        .o_recv_we    (recv_we),
        .o_recv_ptr   (recv_ptr),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
